FILE: rtl/core/rcac_pkg.sv
// ----------------------------------------------------------------------------
// rcac_pkg
// Shared types, codes and lookup functions for the calendar alarm clock.
// ----------------------------------------------------------------------------
package rcac_pkg;

   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_SET     = 2'd1;
   localparam logic [1:0] OP_ARM     = 2'd2;
   localparam logic [1:0] OP_DISMISS = 2'd3;

   localparam logic CSR_ALARM_HOUR   = 1'b0;
   localparam logic CSR_ALARM_MINUTE = 1'b1;

   localparam logic [4:0]  HOUR_MAX    = 5'd23;
   localparam logic [5:0]  MINUTE_MAX  = 6'd59;
   localparam logic [5:0]  SECOND_MAX  = 6'd59;
   localparam logic [3:0]  MONTH_MAX   = 4'd12;
   localparam logic [3:0]  MONTH_MIN   = 4'd1;
   localparam logic [4:0]  DAY_MIN     = 5'd1;
   localparam logic [15:0] COLON_LIMIT = 16'd300;
   localparam logic [7:0]  COLON_SEG   = 8'h40;

   typedef struct packed {
      logic [1:0] opcode;
      logic [4:0] set_hour;
      logic [5:0] set_minute;
      logic [3:0] set_month;
      logic [4:0] set_day;
   } item_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [3:0] month;
      logic [4:0] day;
      logic       armed;
   } time_type;

   localparam time_type RESET_TIME = '{
      hour:   5'd12,
      minute: 6'd0,
      second: 6'd0,
      month:  4'd1,
      day:    5'd1,
      armed:  1'b0
   };

   typedef struct packed {
      logic [7:0] digit0;
      logic [7:0] digit1;
      logic [7:0] colon;
      logic [7:0] digit3;
      logic [7:0] digit4;
   } seg_type;

   function automatic logic [4:0] month_days(input logic [3:0] m);
      logic [4:0] len;
      unique case (m)
         4'd2:                      len = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [3:0] tens_of(input logic [5:0] v);
      logic [3:0] t;
      priority if (v >= 6'd60) t = 4'd6;
      else if (v >= 6'd50) t = 4'd5;
      else if (v >= 6'd40) t = 4'd4;
      else if (v >= 6'd30) t = 4'd3;
      else if (v >= 6'd20) t = 4'd2;
      else if (v >= 6'd10) t = 4'd1;
      else t = 4'd0;
      return t;
   endfunction

   function automatic logic [3:0] units_of(input logic [5:0] v);
      logic [5:0] t;
      logic [5:0] rem;
      t   = {2'b00, tens_of(v)};
      rem = v - ((t << 3) + (t << 1));
      return rem[3:0];
   endfunction

   function automatic logic [7:0] seg_code(input logic [3:0] d);
      logic [7:0] s;
      unique case (d)
         4'd0:    s = 8'h3F;
         4'd1:    s = 8'h06;
         4'd2:    s = 8'h5B;
         4'd3:    s = 8'h4F;
         4'd4:    s = 8'h66;
         4'd5:    s = 8'h6D;
         4'd6:    s = 8'h7D;
         4'd7:    s = 8'h07;
         4'd8:    s = 8'h7F;
         4'd9:    s = 8'h6F;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

endpackage

FILE: rtl/core/rcac_time.sv
// ----------------------------------------------------------------------------
// rcac_time
// Time and date counters, set and alarm opcodes, and the next-state view.
// ----------------------------------------------------------------------------
module rcac_time
   import rcac_pkg::*;
#(
   parameter int TICKS_PER_SECOND = 1000
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   input  logic [4:0] alarm_hour,
   input  logic [5:0] alarm_minute,
   output time_type   time_next,
   output logic       ringing_next,
   output logic       colon_on
);

   localparam int MS_W = $clog2(TICKS_PER_SECOND);
   localparam logic [MS_W-1:0] MS_LAST = MS_W'(TICKS_PER_SECOND - 1);

   logic [MS_W-1:0] milli_ff;
   logic [MS_W-1:0] milli_in;
   time_type        clk_ff;
   time_type        clk_in;
   logic            ring_now;
   logic [3:0]      month_set;
   logic [4:0]      len_set;

   always_comb begin
      milli_in  = milli_ff;
      clk_in    = clk_ff;
      ring_now  = clk_ff.armed && (clk_ff.hour == alarm_hour)
                  && (clk_ff.minute == alarm_minute);
      month_set = item.set_month;
      if (month_set < MONTH_MIN) month_set = MONTH_MIN;
      if (month_set > MONTH_MAX) month_set = MONTH_MAX;
      len_set   = month_days(month_set);
      unique case (item.opcode)
         OP_TICK: begin
            if (milli_ff != MS_LAST) begin
               milli_in = milli_ff + 1'b1;
            end else begin
               milli_in = '0;
               if (clk_ff.second != SECOND_MAX) begin
                  clk_in.second = clk_ff.second + 6'd1;
               end else begin
                  clk_in.second = 6'd0;
                  if (clk_ff.minute != MINUTE_MAX) begin
                     clk_in.minute = clk_ff.minute + 6'd1;
                  end else begin
                     clk_in.minute = 6'd0;
                     if (clk_ff.hour != HOUR_MAX) begin
                        clk_in.hour = clk_ff.hour + 5'd1;
                     end else begin
                        clk_in.hour = 5'd0;
                        if (clk_ff.day < month_days(clk_ff.month)) begin
                           clk_in.day = clk_ff.day + 5'd1;
                        end else begin
                           clk_in.day   = DAY_MIN;
                           clk_in.month = (clk_ff.month >= MONTH_MAX) ? MONTH_MIN
                                          : clk_ff.month + 4'd1;
                        end
                     end
                  end
               end
            end
         end
         OP_SET: begin
            clk_in.hour   = (item.set_hour > HOUR_MAX) ? HOUR_MAX : item.set_hour;
            clk_in.minute = (item.set_minute > MINUTE_MAX) ? MINUTE_MAX
                            : item.set_minute;
            clk_in.month  = month_set;
            if (item.set_day < DAY_MIN) begin
               clk_in.day = DAY_MIN;
            end else if (item.set_day > len_set) begin
               clk_in.day = len_set;
            end else begin
               clk_in.day = item.set_day;
            end
         end
         OP_ARM: begin
            clk_in.armed = !clk_ff.armed;
         end
         OP_DISMISS: begin
            if (ring_now) clk_in.armed = 1'b0;
         end
         default: begin
            clk_in = clk_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         milli_ff <= '0;
         clk_ff   <= RESET_TIME;
      end else if (advance) begin
         milli_ff <= milli_in;
         clk_ff   <= clk_in;
      end
   end

   assign time_next    = clk_in;
   assign ringing_next = clk_in.armed && (clk_in.hour == alarm_hour)
                         && (clk_in.minute == alarm_minute);
   assign colon_on     = 16'(milli_in) < COLON_LIMIT;

`ifndef NO_ASSERTIONS
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      (clk_ff.hour <= HOUR_MAX) && (clk_ff.minute <= MINUTE_MAX)
      && (clk_ff.second <= SECOND_MAX) && (clk_ff.month >= MONTH_MIN)
      && (clk_ff.month <= MONTH_MAX) && (milli_ff <= MS_LAST))
      else $error("time counters left their range");
   a_day_range: assert property (@(posedge clock) disable iff (reset)
      (clk_ff.day >= DAY_MIN) && (clk_ff.day <= month_days(clk_ff.month)))
      else $error("day is outside the length of its month");
   a_milli_wrap: assert property (@(posedge clock) disable iff (reset)
      advance && (item.opcode == OP_TICK) && (milli_ff == MS_LAST)
      |=> (milli_ff == '0))
      else $error("millisecond counter did not wrap at the second boundary");
`endif

endmodule

FILE: rtl/core/rcac_display.sv
// ----------------------------------------------------------------------------
// rcac_display
// Seven-segment decode of HH:MM with a blanked leading hour zero and colon.
// ----------------------------------------------------------------------------
module rcac_display
   import rcac_pkg::*;
(
   input  time_type t,
   input  logic     colon_on,
   output seg_type  seg
);

   logic [5:0] hour_wide;

   assign hour_wide = {1'b0, t.hour};

   always_comb begin
      seg.digit0 = (t.hour < 5'd10) ? 8'h00 : seg_code(tens_of(hour_wide));
      seg.digit1 = seg_code(units_of(hour_wide));
      seg.colon  = colon_on ? COLON_SEG : 8'h00;
      seg.digit3 = seg_code(tens_of(t.minute));
      seg.digit4 = seg_code(units_of(t.minute));
   end

endmodule

FILE: rtl/core/rtc_calendar_alarm_clock.sv
// ----------------------------------------------------------------------------
// rtc_calendar_alarm_clock
// Millisecond-driven clock and calendar with a daily alarm and HH:MM display.
//
//   channel   direction   handshake              payload
//   req       in          req_valid, req_stall   opcode and set fields
//   rsp       out         rsp_valid, rsp_stall   time, date, alarm, segments
//   csr       in          csr_write_enable       csr_index, csr_wdata
//
// One item per cycle sustained while rsp_stall is low; each item moves from the
// input register to the result register when the result register is free.
// The counter cascade, set clamping and segment decode all settle combinationally.
// Reset is synchronous and loads 12:00:00 on January 1 with the alarm disarmed.
// A stalled result holds its register; the input register still takes one beat.
// ----------------------------------------------------------------------------
module rtc_calendar_alarm_clock
   import rcac_pkg::*;
#(
   parameter int TICKS_PER_SECOND = 1000
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_opcode,
   input  logic [4:0] req_set_hour,
   input  logic [5:0] req_set_minute,
   input  logic [3:0] req_set_month,
   input  logic [4:0] req_set_day,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [4:0] rsp_cur_hour,
   output logic [5:0] rsp_cur_minute,
   output logic [5:0] rsp_cur_second,
   output logic [3:0] rsp_cur_month,
   output logic [4:0] rsp_cur_day,
   output logic       rsp_ringing,
   output logic       rsp_armed_flag,
   output logic [7:0] rsp_seg_digit0,
   output logic [7:0] rsp_seg_digit1,
   output logic [7:0] rsp_seg_colon,
   output logic [7:0] rsp_seg_digit3,
   output logic [7:0] rsp_seg_digit4,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [5:0] csr_wdata
);

   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   in_item_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   time_type   rsp_time_ff;
   logic       rsp_ring_ff;
   seg_type    rsp_seg_ff;
   logic [4:0] alarm_hour_ff;
   logic [5:0] alarm_minute_ff;
   logic       advance;
   logic       req_take;
   time_type   time_next;
   logic       ringing_next;
   logic       colon_on;
   seg_type    seg_next;

   assign advance      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= '{
            opcode:     req_opcode,
            set_hour:   req_set_hour,
            set_minute: req_set_minute,
            set_month:  req_set_month,
            set_day:    req_set_day
         };
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_hour_ff   <= 5'd0;
         alarm_minute_ff <= 6'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ALARM_HOUR:   alarm_hour_ff   <= csr_wdata[4:0];
            CSR_ALARM_MINUTE: alarm_minute_ff <= csr_wdata;
            default:          alarm_hour_ff   <= alarm_hour_ff;
         endcase
      end
   end

   rcac_time #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_time (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .item         (in_item_ff),
      .alarm_hour   (alarm_hour_ff),
      .alarm_minute (alarm_minute_ff),
      .time_next    (time_next),
      .ringing_next (ringing_next),
      .colon_on     (colon_on)
   );

   rcac_display u_display (
      .t        (time_next),
      .colon_on (colon_on),
      .seg      (seg_next)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_time_ff <= time_next;
         rsp_ring_ff <= ringing_next;
         rsp_seg_ff  <= seg_next;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cur_hour   = rsp_time_ff.hour;
   assign rsp_cur_minute = rsp_time_ff.minute;
   assign rsp_cur_second = rsp_time_ff.second;
   assign rsp_cur_month  = rsp_time_ff.month;
   assign rsp_cur_day    = rsp_time_ff.day;
   assign rsp_ringing    = rsp_ring_ff;
   assign rsp_armed_flag = rsp_time_ff.armed;
   assign rsp_seg_digit0 = rsp_seg_ff.digit0;
   assign rsp_seg_digit1 = rsp_seg_ff.digit1;
   assign rsp_seg_colon  = rsp_seg_ff.colon;
   assign rsp_seg_digit3 = rsp_seg_ff.digit3;
   assign rsp_seg_digit4 = rsp_seg_ff.digit4;

`ifndef NO_ASSERTIONS
   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("an advancing beat did not reach the result register");
   a_empty_never_stalls: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("input stalled with an empty input register");
   a_ring_needs_arm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ring_ff |-> rsp_time_ff.armed)
      else $error("result rings while the alarm is disarmed");
`endif

endmodule
